// File: sv/atc_pkg.sv
`timescale 1ns / 1ps

package atc_pkg;

  // default token store depth
  localparam int unsigned TokenCapacityDef = 32;

  localparam int unsigned ChecksumW = 32;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned PosW      = 5;
  localparam int unsigned LenW      = 6;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 32;

  // collected bytes are stored with the flipped bit undone
  localparam logic [ByteW-1:0] FlipMask = 8'h01;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BASELINE = 2'd0,
    REG_MIN_LEN  = 2'd1,
    REG_ENABLE   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [ChecksumW-1:0] trace_checksum;
    logic [ByteW-1:0]     input_byte;
    logic                 first_flip;
    logic                 last_flip;
  } in_item_t;

  typedef struct packed {
    logic [ByteW-1:0] token_byte;
    logic [PosW-1:0]  byte_position;
    logic [LenW-1:0]  token_length;
    logic             last_byte;
  } out_item_t;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_CMP_PREV = 8'b0000_0010,
    S_CMP_BASE = 8'b0000_0100,
    S_ACT      = 8'b0000_1000,
    S_CHK      = 8'b0001_0000,
    S_RD       = 8'b0010_0000,
    S_OUT      = 8'b0100_0000,
    S_POST     = 8'b1000_0000
  } state_e;

endpackage

// File: sv/atc_in_if.sv
`timescale 1ns / 1ps

interface atc_in_if import atc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/atc_out_if.sv
`timescale 1ns / 1ps

interface atc_out_if import atc_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/auto_token_collector_top.sv
`timescale 1ns / 1ps

// token collector for single-bit-flip results
// in_i carries one flip result per item: trace checksum, input byte at the
// flipped position, first and last flip marks. out_i carries one token byte
// per item with its position, the token length and a last-byte mark.
// cfg_we_i / cfg_idx_i / cfg_data_i write the baseline checksum, the minimum
// token length and the collect enable; write them only while idle.
// a run of flips with the same checksum, differing from the baseline,
// collects its bytes; a change of checksum or the last flip emits the run
// if its length lies between the minimum and the capacity
// one item at a time passes through a small sequencer around a single
// 32-bit equality comparator; an accepted item passes the compare-previous,
// compare-baseline and act steps, then a check step when the run is checked
// for output (checksum changed or last flip on the same checksum), then a
// store read and the output register per emitted token byte, held while the
// receiver holds ready low, and a post step before ready returns
// with collection disabled an item is accepted and dropped in the idle state, so ready stays high
// the output register holds its byte steady while the receiver stalls
// reset clears the checksum and run length state and loads register
// defaults (baseline 0, minimum 3, enabled); the token store is not cleared,
// only bytes written during the current run are ever read
module auto_token_collector_top import atc_pkg::*; #(
  parameter int unsigned TokenCapacity = TokenCapacityDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  atc_in_if.sink              in_i,
  atc_out_if.source           out_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // run length saturates at capacity plus one
  localparam int unsigned RunW  = $clog2(TokenCapacity + 2);
  localparam int unsigned AddrW = $clog2(TokenCapacity);
  localparam int unsigned CmpW  = (RunW > LenW) ? RunW : LenW;
  localparam logic [RunW-1:0] CapRun = RunW'(TokenCapacity);

  // configuration registers
  logic [ChecksumW-1:0] baseline_q;
  logic [LenW-1:0]      min_len_q;
  logic                 enable_q;

  // sequencer state
  state_e               state_q, state_d;
  logic [ChecksumW-1:0] prev_q;
  logic [RunW-1:0]      run_q, run_d;
  logic [RunW-1:0]      k_q;
  logic                 eq_prev_q, eq_base_q, clear_q;

  // latched item
  logic [ChecksumW-1:0] ck_q;
  logic [ByteW-1:0]     byte_q;
  logic                 first_q, last_q;

  // token store and its registered read
  logic [ByteW-1:0]     store_q [TokenCapacity];
  logic [ByteW-1:0]     rd_byte_q;
  logic                 mem_we;
  logic [RunW-1:0]      mem_ptr;

  logic                 in_acc, out_acc;
  logic [ChecksumW-1:0] cmp_b;
  logic                 cmp_eq;
  logic [RunW-1:0]      run_base;
  logic                 fit;

  assign in_acc  = in_i.valid & in_i.ready;
  assign out_acc = out_i.valid & out_i.ready;

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_i.valid = (state_q == S_OUT);
  assign out_i.data.token_byte    = rd_byte_q;
  assign out_i.data.byte_position = PosW'(k_q);
  assign out_i.data.token_length  = LenW'(run_q);
  assign out_i.data.last_byte     = ((k_q + RunW'(1)) == run_q);

  // shared comparator: previous checksum first (baseline on a first flip),
  // then the baseline
  always_comb begin
    if (state_q == S_CMP_PREV) begin
      cmp_b = first_q ? baseline_q : prev_q;
    end else begin
      cmp_b = baseline_q;
    end
  end
  assign cmp_eq = (ck_q == cmp_b);

  // run restarts before the trailing collect when the checksum changed
  assign run_base = clear_q ? '0 : run_q;

  assign fit = (run_q != '0) && (CmpW'(run_q) >= CmpW'(min_len_q)) && (run_q <= CapRun);

  // store write and run length: reset on a first flip, collect in the act step or the trailing collect
  always_comb begin
    mem_we  = 1'b0;
    mem_ptr = run_q;
    run_d   = run_q;
    case (state_q)
      S_CMP_PREV: begin
        if (first_q) begin
          run_d = '0;
        end
      end
      S_ACT: begin
        if (last_q && eq_prev_q) begin
          mem_we = (run_q < CapRun);
          if (run_q <= CapRun) begin
            run_d = run_q + RunW'(1);
          end
        end
      end
      S_POST: begin
        mem_ptr = run_base;
        run_d   = run_base;
        if (!eq_base_q) begin
          mem_we = (run_base < CapRun);
          if (run_base <= CapRun) begin
            run_d = run_base + RunW'(1);
          end
        end
      end
      default: begin
        run_d = run_q;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:     if (in_acc && enable_q) state_d = S_CMP_PREV;
      S_CMP_PREV: state_d = S_CMP_BASE;
      S_CMP_BASE: state_d = S_ACT;
      S_ACT:      state_d = ((last_q && eq_prev_q) || !eq_prev_q) ? S_CHK : S_POST;
      S_CHK:      state_d = fit ? S_RD : S_POST;
      S_RD:       state_d = S_OUT;
      S_OUT: begin
        if (out_acc) begin
          state_d = out_i.data.last_byte ? S_POST : S_RD;
        end
      end
      S_POST:     state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // configuration writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      baseline_q <= '0;
      min_len_q  <= LenW'(3);
      enable_q   <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BASELINE: baseline_q <= cfg_data_i;
        REG_MIN_LEN:  min_len_q  <= cfg_data_i[LenW-1:0];
        REG_ENABLE:   enable_q   <= cfg_data_i[0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      prev_q    <= '0;
      run_q     <= '0;
      k_q       <= '0;
      eq_prev_q <= 1'b0;
      eq_base_q <= 1'b0;
      clear_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      run_q   <= run_d;
      case (state_q)
        S_CMP_PREV: begin
          eq_prev_q <= cmp_eq;
          if (first_q) begin
            prev_q <= baseline_q;
          end
        end
        S_CMP_BASE: eq_base_q <= cmp_eq;
        S_ACT:      clear_q <= !eq_prev_q;
        S_CHK:      k_q <= '0;
        S_OUT: begin
          if (out_acc) begin
            k_q <= k_q + RunW'(1);
          end
        end
        S_POST: begin
          if (clear_q) begin
            prev_q <= ck_q;
          end
        end
        default: ;
      endcase
    end
  end

  // item payload latch
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ck_q    <= in_i.data.trace_checksum;
      byte_q  <= in_i.data.input_byte;
      first_q <= in_i.data.first_flip;
      last_q  <= in_i.data.last_flip;
    end
  end

  // token store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[mem_ptr[AddrW-1:0]] <= byte_q ^ FlipMask;
    end
    if (state_q == S_RD) begin
      rd_byte_q <= store_q[k_q[AddrW-1:0]];
    end
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import atc_pkg::*;

  // cycles to let pass once the last token byte is in: a flip that makes no
  // token can still be working its way through the sequencer
  localparam int unsigned SettleCycles = 16;
  // the register index with no register behind it
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;

  // tracks the run of equal checksums and the token bytes it must produce
  class token_tracker;
    logic [ChecksumW-1:0] baseline_ck;
    logic [LenW-1:0]      min_len;
    logic                 collect_en;
    logic [ChecksumW-1:0] last_ck;
    logic [ByteW-1:0]     run_bytes [TokenCapacityDef];
    int unsigned          run_len;
    out_item_t            pending_bytes [$];
    int unsigned          errors;

    function new();
      baseline_ck = '0;
      min_len     = LenW'(3);
      collect_en  = 1'b1;
      last_ck     = '0;
      run_len     = 0;
      errors      = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        REG_BASELINE: baseline_ck = val[ChecksumW-1:0];
        REG_MIN_LEN:  min_len     = val[LenW-1:0];
        REG_ENABLE:   collect_en  = val[0];
        default: ;
      endcase
    endfunction

    function void append_byte(logic [ByteW-1:0] b);
      if (run_len < TokenCapacityDef) run_bytes[run_len] = b ^ FlipMask;
      if (run_len <= TokenCapacityDef) run_len++;
    endfunction

    function void flush_token();
      out_item_t t;
      if (run_len < min_len || run_len > TokenCapacityDef) return;
      for (int unsigned k = 0; k < run_len; k++) begin
        t.token_byte    = run_bytes[k];
        t.byte_position = PosW'(k);
        t.token_length  = LenW'(run_len);
        t.last_byte     = (k + 1 == run_len);
        pending_bytes.push_back(t);
      end
    endfunction

    function void note_flip(in_item_t f);
      if (!collect_en) return;
      if (f.first_flip) begin
        last_ck = baseline_ck;
        run_len = 0;
      end
      if (f.last_flip && f.trace_checksum == last_ck) begin
        append_byte(f.input_byte);
        flush_token();
      end else if (f.trace_checksum != last_ck) begin
        flush_token();
        run_len = 0;
        last_ck = f.trace_checksum;
      end
      if (f.trace_checksum != baseline_ck) append_byte(f.input_byte);
    endfunction

    task report(string msg);
      errors++;
      // keep the log short when things go badly wrong
      if (errors <= 50) $display("mismatch: %s", msg);
    endtask

    task check_token_byte(out_item_t got);
      out_item_t want;
      if (pending_bytes.size() == 0) begin
        report($sformatf("token byte %h arrived with none outstanding", got));
        return;
      end
      want = pending_bytes.pop_front();
      if (got.token_byte !== want.token_byte)
        report($sformatf("token_byte got %h want %h", got.token_byte, want.token_byte));
      if (got.byte_position !== want.byte_position)
        report($sformatf("byte_position got %0d want %0d",
                         got.byte_position, want.byte_position));
      if (got.token_length !== want.token_length)
        report($sformatf("token_length got %0d want %0d",
                         got.token_length, want.token_length));
      if (got.last_byte !== want.last_byte)
        report($sformatf("last_byte got %b want %b", got.last_byte, want.last_byte));
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  atc_in_if  in_if ();
  atc_out_if out_if ();

  token_tracker tracker = new();

  // flips accepted while collecting; sets how long the random part runs
  int unsigned flips_sent;
  // sender runs a stage back to back when set
  bit          tx_burst;

  auto_token_collector_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_i      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // one register write; the leading edge keeps the enable from being lowered
  // and raised in the same step when writes follow each other
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    tracker.set_reg(idx, val);
  endtask

  // offer one flip result after a random gap and hold it until taken
  task automatic send_flip(input logic [ChecksumW-1:0] ck, input logic [ByteW-1:0] b,
                           input logic is_first, input logic is_last);
    in_item_t    f;
    int unsigned gap;
    f.trace_checksum = ck;
    f.input_byte     = b;
    f.first_flip     = is_first;
    f.last_flip      = is_last;
    gap = tx_burst ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= f;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    if (tracker.collect_en) flips_sent++;
    tracker.note_flip(f);
  endtask

  // checksums drawn mostly from a small pool so that runs form and repeat
  function automatic logic [ChecksumW-1:0] pick_checksum();
    case ($urandom_range(0, 5))
      0:       return tracker.baseline_ck;
      1:       return tracker.last_ck;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // mostly well-formed stages (first flip, runs of equal checksums, last
  // flip), now and then a burst of flips with random marks
  task automatic random_flips(input int unsigned upto);
    logic [ChecksumW-1:0] ck;
    int unsigned          runs;
    int unsigned          len;
    while (flips_sent < upto) begin
      tx_burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 4))
          send_flip(pick_checksum(), 8'($urandom), 1'($urandom), 1'($urandom));
      end else begin
        runs = $urandom_range(1, 4);
        for (int unsigned r = 0; r < runs; r++) begin
          ck  = pick_checksum();
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 5);
          for (int unsigned i = 0; i < len; i++)
            send_flip(ck, 8'($urandom), r == 0 && i == 0, r + 1 == runs && i + 1 == len);
        end
      end
    end
    tx_burst = 1'b0;
  endtask

  // let every outstanding token byte arrive, then let the sequencer settle
  task automatic drain();
    in_if.valid <= 1'b0;
    while (tracker.pending_bytes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // receiver: random stalls per item, stretches without stalls, and two long
  // hold-offs so the sequencer backs up into the input while flips keep coming
  initial begin : token_sink
    int unsigned gap;
    int unsigned hold_left;
    int unsigned taken;
    bit          rx_burst;
    gap       = 0;
    hold_left = 0;
    taken     = 0;
    rx_burst  = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        tracker.check_token_byte(out_if.data);
        taken++;
        if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
        gap = rx_burst ? 0 : $urandom_range(0, 7);
        // the first hold lands inside the full-capacity token
        if (taken == 20 || taken == 60) hold_left = 300;
      end else if (gap != 0) begin
        gap--;
      end
      if (hold_left != 0) hold_left--;
      out_if.ready <= (gap == 0 && hold_left == 0);
    end
  end

  initial begin : stimulus
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= REG_BASELINE;
    cfg_data_i  <= '0;
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    flips_sent  = 0;
    tx_burst    = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // register defaults: baseline 0, minimum 3, collecting
    // first flip on the baseline: nothing collected
    send_flip(32'h0000_0000, 8'h00, 1'b1, 1'b0);
    // three equal flips with the all-ones checksum, extreme bytes
    send_flip(32'hFFFF_FFFF, 8'hFF, 1'b0, 1'b0);
    send_flip(32'hFFFF_FFFF, 8'h00, 1'b0, 1'b0);
    send_flip(32'hFFFF_FFFF, 8'h80, 1'b0, 1'b0);
    // back to the baseline: the three-byte run comes out
    send_flip(32'h0000_0000, 8'h55, 1'b0, 1'b0);
    // short run, then a last flip on the same checksum that completes it,
    // emits it and collects the byte a second time
    send_flip(32'h0000_0005, 8'h7F, 1'b0, 1'b0);
    send_flip(32'h0000_0005, 8'h01, 1'b0, 1'b0);
    send_flip(32'h0000_0005, 8'hAA, 1'b0, 1'b1);
    // another last flip: the continued run of five comes out
    send_flip(32'h0000_0005, 8'h11, 1'b0, 1'b1);
    // first and last on one flip with a new checksum
    send_flip(32'h8000_0001, 8'h0F, 1'b1, 1'b1);
    send_flip(32'h8000_0001, 8'hF0, 1'b0, 1'b0);
    // last flip on the baseline after a first flip: one byte, too short
    send_flip(32'h0000_0000, 8'h22, 1'b1, 1'b1);
    send_flip(32'h0000_0000, 8'h33, 1'b0, 1'b0);
    send_flip(32'h0000_0000, 8'h44, 1'b0, 1'b0);
    send_flip(32'h7FFF_FFFE, 8'h00, 1'b0, 1'b0);
    send_flip(32'h7FFF_FFFE, 8'hFF, 1'b0, 1'b0);
    send_flip(32'h7FFF_FFFE, 8'h5A, 1'b0, 1'b1);
    // a first flip in mid-run throws the run away and starts afresh
    send_flip(32'h7FFF_FFFE, 8'hC3, 1'b1, 1'b0);
    send_flip(32'h7FFF_FFFE, 8'h3C, 1'b0, 1'b0);
    send_flip(32'h7FFF_FFFE, 8'h96, 1'b0, 1'b0);
    send_flip(32'h0000_0000, 8'h69, 1'b0, 1'b0);
    drain();

    // all-ones baseline, minimum at capacity
    write_reg(REG_BASELINE, 32'hFFFF_FFFF);
    write_reg(REG_MIN_LEN, {26'($urandom), 6'd32});
    // a full-capacity token, then an over-long run that saturates and never
    // comes out, not even on its last flip
    send_flip(32'hFFFF_FFFF, 8'($urandom), 1'b1, 1'b0);
    repeat (32) send_flip(32'h1357_9BDF, 8'($urandom), 1'b0, 1'b0);
    repeat (32) send_flip(32'h0000_0000, 8'($urandom), 1'b0, 1'b0);
    send_flip(32'h0000_0000, 8'($urandom), 1'b0, 1'b1);
    send_flip(32'h1357_9BDF, 8'($urandom), 1'b0, 1'b0);
    drain();

    // random baseline, minimum of one, and a write to the unused index
    write_reg(REG_BASELINE, $urandom);
    write_reg(REG_MIN_LEN, {26'($urandom), 6'd1});
    write_reg(RegUnused, $urandom);
    random_flips(92);
    drain();

    // minimum of zero on a zero baseline
    write_reg(REG_BASELINE, 32'h0000_0000);
    write_reg(REG_MIN_LEN, {26'($urandom), 6'd0});
    random_flips(96);
    drain();

    // minimum above capacity: runs collect but nothing comes out
    write_reg(REG_MIN_LEN, {26'($urandom), 6'd63});
    random_flips(100);
    drain();

    // collection off: flips, first flips included, leave no trace
    write_reg(REG_ENABLE, $urandom & ~32'h1);
    send_flip(pick_checksum(), 8'($urandom), 1'b1, 1'b0);
    repeat (5) send_flip(pick_checksum(), 8'($urandom), 1'($urandom), 1'($urandom));
    drain();

    // back on, the run from before the pause carries on
    write_reg(REG_ENABLE, $urandom | 32'h1);
    write_reg(REG_MIN_LEN, {26'($urandom), 6'd3});
    send_flip(tracker.last_ck, 8'($urandom), 1'b0, 1'b0);
    send_flip(tracker.last_ck, 8'($urandom), 1'b0, 1'b1);
    random_flips(104);
    drain();

    if (tracker.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // run limit, well beyond the slowest correct run
  initial begin : run_limit
    #(5_000_000);
    $display("FAILURE");
    $finish;
  end

endmodule
